>>> rtl/gravity_pose_moment_accumulator_core_defines.svh
// Assertion macros shared by the moment accumulator RTL.
// No dependencies.
`ifndef GRAVITY_POSE_MOMENT_ACCUMULATOR_CORE_DEFINES_SVH
`define GRAVITY_POSE_MOMENT_ACCUMULATOR_CORE_DEFINES_SVH
`define GPMA_ASSERT_IMPL(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
`define GPMA_ASSERT_NEXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/gpma_pkg.sv
// Shared types, constants and term table for the moment accumulator.
// No dependencies.
package gpma_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC = COORD_BITS - 2;
    localparam int RSHIFT = 4 * FRAC - 28;
    localparam int NSLOT = 30;
    localparam int NTERM = 45;
    localparam int SLOT_W = 5;
    localparam int TERM_W = 6;
    localparam int W_BITS = 2 * COORD_BITS + 2;
    localparam int P_BITS = 2 * W_BITS + 2;
    localparam int ACC_W = 64;
    localparam int PART_W = P_BITS + 4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TERMS, ST_MERGE, ST_EMIT
    } gpma_state_t;

    typedef struct packed {
        logic load;
        logic clear_part;
        logic term_en;
        logic [TERM_W-1:0] term_idx;
        logic merge_en;
        logic [SLOT_W-1:0] slot_idx;
        logic emit_clear;
    } gpma_cmd_t;

    typedef struct packed {
        logic [TERM_W-1:0] slot;
        logic signed [2:0] mult;
        logic [3:0] wa;
        logic [3:0] wb;
    } term_t;

    function automatic term_t term_entry(input logic [TERM_W-1:0] i);
        term_t t;
        case (i)
            6'd0: t = '{6'd4, 3'sd1, 4'd0, 4'd0};
            6'd1: t = '{6'd3, 3'sd2, 4'd0, 4'd1};
            6'd2: t = '{6'd2, 3'sd1, 4'd1, 4'd1};
            6'd3: t = '{6'd2, 3'sd2, 4'd0, 4'd2};
            6'd4: t = '{6'd1, 3'sd2, 4'd1, 4'd2};
            6'd5: t = '{6'd0, 3'sd1, 4'd2, 4'd2};
            6'd6: t = '{6'd9, 3'sd1, 4'd0, 4'd3};
            6'd7: t = '{6'd8, 3'sd1, 4'd0, 4'd4};
            6'd8: t = '{6'd8, 3'sd1, 4'd1, 4'd3};
            6'd9: t = '{6'd7, 3'sd1, 4'd1, 4'd4};
            6'd10: t = '{6'd7, -3'sd1, 4'd0, 4'd3};
            6'd11: t = '{6'd7, 3'sd1, 4'd2, 4'd3};
            6'd12: t = '{6'd6, 3'sd1, 4'd2, 4'd4};
            6'd13: t = '{6'd6, -3'sd1, 4'd1, 4'd3};
            6'd14: t = '{6'd5, -3'sd1, 4'd2, 4'd3};
            6'd15: t = '{6'd14, 3'sd1, 4'd0, 4'd6};
            6'd16: t = '{6'd13, 3'sd1, 4'd0, 4'd7};
            6'd17: t = '{6'd13, 3'sd1, 4'd1, 4'd6};
            6'd18: t = '{6'd12, 3'sd1, 4'd0, 4'd8};
            6'd19: t = '{6'd12, 3'sd1, 4'd1, 4'd7};
            6'd20: t = '{6'd12, 3'sd1, 4'd2, 4'd6};
            6'd21: t = '{6'd11, 3'sd1, 4'd1, 4'd8};
            6'd22: t = '{6'd11, 3'sd1, 4'd2, 4'd7};
            6'd23: t = '{6'd10, 3'sd1, 4'd2, 4'd8};
            6'd24: t = '{6'd19, 3'sd1, 4'd3, 4'd3};
            6'd25: t = '{6'd18, 3'sd2, 4'd3, 4'd4};
            6'd26: t = '{6'd17, 3'sd1, 4'd4, 4'd4};
            6'd27: t = '{6'd17, -3'sd2, 4'd3, 4'd3};
            6'd28: t = '{6'd16, -3'sd2, 4'd3, 4'd4};
            6'd29: t = '{6'd15, 3'sd1, 4'd3, 4'd3};
            6'd30: t = '{6'd24, 3'sd1, 4'd3, 4'd6};
            6'd31: t = '{6'd23, 3'sd1, 4'd3, 4'd7};
            6'd32: t = '{6'd23, 3'sd1, 4'd4, 4'd6};
            6'd33: t = '{6'd22, 3'sd1, 4'd3, 4'd8};
            6'd34: t = '{6'd22, -3'sd1, 4'd3, 4'd6};
            6'd35: t = '{6'd22, 3'sd1, 4'd4, 4'd7};
            6'd36: t = '{6'd21, 3'sd1, 4'd4, 4'd8};
            6'd37: t = '{6'd21, -3'sd1, 4'd3, 4'd7};
            6'd38: t = '{6'd20, -3'sd1, 4'd3, 4'd8};
            6'd39: t = '{6'd29, 3'sd1, 4'd6, 4'd6};
            6'd40: t = '{6'd28, 3'sd2, 4'd6, 4'd7};
            6'd41: t = '{6'd27, 3'sd1, 4'd7, 4'd7};
            6'd42: t = '{6'd27, 3'sd2, 4'd6, 4'd8};
            6'd43: t = '{6'd26, 3'sd2, 4'd7, 4'd8};
            6'd44: t = '{6'd25, 3'sd1, 4'd8, 4'd8};
            default: t = '{6'd0, 3'sd0, 4'd0, 4'd0};
        endcase
        return t;
    endfunction
endpackage

>>> rtl/gpma_datapath.sv
// Datapath: intermediate terms, one product per cycle into per-slot partial
// sums, then rounding and saturating merge into the accumulators. Uses gpma_pkg.
module gpma_datapath (
    input  logic                                 aclk,
    input  gpma_pkg::gpma_cmd_t                  cmd,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] px,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] py,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] qx,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] qy,
    output logic signed [gpma_pkg::ACC_W-1:0]    emit_value
);
    import gpma_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB + 1;
    localparam int SH_W = PART_W - RSHIFT;
    localparam int CW = ACC_W + SH_W;

    logic signed [W_BITS-1:0] w_reg [9];
    logic signed [PART_W-1:0] part_reg [NSLOT];
    logic signed [ACC_W-1:0] acc_reg [NSLOT];
    logic signed [P_BITS-1:0] prod_reg;
    logic [SLOT_W-1:0] prod_slot_reg;
    logic prod_vld_reg;

    logic signed [PW-1:0] u1, u2, uxx;
    term_t te;
    logic signed [P_BITS-1:0] prod_next;
    logic signed [PART_W-1:0] rnd;
    logic signed [SH_W-1:0] shr;
    logic signed [ACC_W-1:0] nar, acc_cur;
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W-1:0] acc_next;

    localparam logic signed [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-1){1'b0}}};

    assign u1 = PW'(px * qy);
    assign u2 = PW'(qx * py);
    assign uxx = PW'(px * qx);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg[0] <= W_BITS'(-(W_BITS'(qy) + W_BITS'(py))) <<< FRAC;
            w_reg[1] <= -(W_BITS'(u1) <<< 1);
            w_reg[2] <= (W_BITS'(qy) - W_BITS'(py)) <<< FRAC;
            w_reg[3] <= (W_BITS'(qx) - W_BITS'(px)) <<< FRAC;
            w_reg[4] <= (W_BITS'(1) <<< (2 * FRAC + 1)) + (W_BITS'(uxx) <<< 1);
            w_reg[5] <= '0;
            w_reg[6] <= W_BITS'(u1) + W_BITS'(u2);
            w_reg[7] <= -(W_BITS'(qy) <<< (FRAC + 1));
            w_reg[8] <= W_BITS'(u2) - W_BITS'(u1);
        end
    end

    // One product a cycle; its scale by the term multiplier is a shift and negate.
    always_comb begin
        te = term_entry(cmd.term_idx);
        prod_next = P_BITS'(w_reg[te.wa]) * P_BITS'(w_reg[te.wb]);
        if (te.mult == 3'sd2 || te.mult == -3'sd2) prod_next = prod_next <<< 1;
        if (te.mult < 0) prod_next = -prod_next;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        prod_slot_reg <= SLOT_W'(te.slot);
        prod_vld_reg <= cmd.term_en;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSLOT; i++) begin
            if (cmd.clear_part) part_reg[i] <= '0;
            else if (prod_vld_reg && prod_slot_reg == SLOT_W'(i))
                part_reg[i] <= part_reg[i] + PART_W'(prod_reg);
        end
    end

    // The limits are compared at a width that holds both the shifted sum and
    // the accumulator range, so neither side is truncated.
    always_comb begin
        rnd = part_reg[cmd.slot_idx] + (PART_W'(1) <<< (RSHIFT - 1));
        shr = rnd[PART_W-1:RSHIFT];
        if (CW'(shr) > CW'(SMAX)) nar = SMAX;
        else if (CW'(shr) < CW'(SMIN)) nar = SMIN;
        else nar = ACC_W'(shr);
        acc_cur = acc_reg[cmd.slot_idx];
        sum = (ACC_W+1)'(acc_cur) + (ACC_W+1)'(nar);
        if (sum[ACC_W] != sum[ACC_W-1]) acc_next = sum[ACC_W] ? SMIN : SMAX;
        else acc_next = sum[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSLOT; i++) begin
            if (cmd.load && cmd.emit_clear) acc_reg[i] <= '0;
            else if (cmd.merge_en && cmd.slot_idx == SLOT_W'(i)) acc_reg[i] <= acc_next;
        end
    end

    assign emit_value = acc_reg[cmd.slot_idx];
endmodule

>>> rtl/gpma_ctrl.sv
// Controller: sequences term products, merges and coefficient emission.
// Uses gpma_pkg.
module gpma_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  logic                      in_final,
    input  logic                      out_ready,
    output logic                      in_ready,
    output logic                      out_valid,
    output logic                      out_last,
    output logic                      clear_pending,
    output gpma_pkg::gpma_cmd_t       cmd
);
    import gpma_pkg::*;

    gpma_state_t state_reg, state_next;
    logic [TERM_W-1:0] cnt_reg, cnt_next;
    logic final_reg, final_next;
    logic clr_reg, clr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            final_reg <= 1'b0;
            clr_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            final_reg <= final_next;
            clr_reg <= clr_next;
        end
    end

    // The term state runs on past the last term with term_en low, so the product register drains into the partial sums.
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        final_next = final_reg;
        clr_next = clr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_TERMS;
                    cnt_next = '0;
                    final_next = in_final;
                    clr_next = 1'b0;
                end
            end
            ST_TERMS: begin
                if (cnt_reg == TERM_W'(NTERM)) begin
                    state_next = ST_MERGE;
                    cnt_next = '0;
                end else cnt_next = cnt_reg + 1'b1;
            end
            ST_MERGE: begin
                if (cnt_reg == TERM_W'(NSLOT - 1)) begin
                    cnt_next = '0;
                    state_next = final_reg ? ST_EMIT : ST_IDLE;
                end else cnt_next = cnt_reg + 1'b1;
            end
            ST_EMIT: begin
                if (out_ready) begin
                    if (cnt_reg == TERM_W'(NSLOT - 1)) begin
                        state_next = ST_IDLE;
                        clr_next = 1'b1;
                    end else cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        out_last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                cmd.clear_part = in_fire;
                cmd.emit_clear = clr_reg;
            end
            ST_TERMS: begin
                cmd.term_en = cnt_reg < TERM_W'(NTERM);
                cmd.term_idx = cnt_reg;
            end
            ST_MERGE: begin
                cmd.merge_en = 1'b1;
                cmd.slot_idx = SLOT_W'(cnt_reg);
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                out_last = cnt_reg == TERM_W'(NSLOT - 1);
                cmd.slot_idx = SLOT_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    assign clear_pending = clr_reg;
endmodule

>>> rtl/gravity_pose_moment_accumulator_core.sv
// Moment accumulator top level: a correspondence passes through the load,
// term and merge states before the next is accepted; a final item then emits
// 30 coefficients, one per transfer, stretched by output stalls. The shared multiplier
// forming one term product per cycle sets the rate.
// Reset (synchronous, active low) clears control; the accumulators are zeroed
// when the first item after reset or after an emission is loaded.
module gravity_pose_moment_accumulator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] s_first_x,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] s_first_y,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] s_second_x,
    input  logic signed [gpma_pkg::COORD_BITS-1:0] s_second_y,
    input  logic                                  s_final_point,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [4:0]                            m_coef_index,
    output logic signed [63:0]                    m_coef_value,
    output logic                                  m_run_end
);
    import gpma_pkg::*;
    `include "gravity_pose_moment_accumulator_core_defines.svh"

    gpma_cmd_t cmd;
    logic in_fire, clr_pend;

    assign in_fire = s_valid && s_ready;

    gpma_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_final(s_final_point), .out_ready(m_ready), .in_ready(s_ready),
        .out_valid(m_valid), .out_last(m_run_end), .clear_pending(clr_pend),
        .cmd(cmd)
    );

    gpma_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .px(s_first_x), .py(s_first_y),
        .qx(s_second_x), .qy(s_second_y), .emit_value(m_coef_value)
    );

    assign m_coef_index = cmd.slot_idx;

    `GPMA_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "input taken during emission")
    `GPMA_ASSERT_IMPL(a_end_index, aclk, aresetn, m_valid && m_run_end, m_coef_index == 5'd29, "run end off last index")
    `GPMA_ASSERT_NEXT(a_clear_after, aclk, aresetn, m_valid && m_ready && m_run_end, clr_pend, "store not marked clear")
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for gravity_pose_moment_accumulator_core.
// Depends on gpma_pkg and the core RTL; drives point correspondences
// and checks every emitted coefficient against an in-bench moment predictor.
`timescale 1ns / 100ps

module tb;
    import gpma_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef struct {
        logic [4:0]         idx;
        logic signed [63:0] val;
        logic               last;
    } coef_t;
    typedef struct {
        logic signed [15:0] px, py, qx, qy;
        logic               fin;
        logic               typed;
    } point_row_t;

    localparam int NUM_RANDOM = 320;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_BITS-1:0] s_first_x = '0, s_first_y = '0;
    logic signed [COORD_BITS-1:0] s_second_x = '0, s_second_y = '0;
    logic s_final_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [4:0] m_coef_index;
    logic signed [63:0] m_coef_value;
    logic m_run_end;

    gravity_pose_moment_accumulator_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Own copy of the term table: slot, multiplier, first w, second w.
    int term_slot[45] = '{4,3,2,2,1,0, 9,8,8,7,7,7,6,6,5, 14,13,13,12,12,12,11,11,10,
                          19,18,17,17,16,15, 24,23,23,22,22,22,21,21,20,
                          29,28,27,27,26,25};
    int term_mul[45] = '{1,2,1,2,2,1, 1,1,1,1,-1,1,1,-1,-1, 1,1,1,1,1,1,1,1,1,
                         1,2,1,-2,-2,1, 1,1,1,1,-1,1,1,-1,-1, 1,2,1,2,2,1};
    int term_wa[45] = '{0,0,1,0,1,2, 0,0,1,1,0,2,2,1,2, 0,0,1,0,1,2,1,2,2,
                        3,3,4,3,3,3, 3,3,4,3,3,4,4,3,3, 6,6,7,6,7,8};
    int term_wb[45] = '{0,1,1,2,2,2, 3,4,3,4,3,3,4,3,3, 6,7,6,8,7,6,8,7,8,
                        3,4,4,3,4,3, 6,7,6,8,6,7,8,7,8, 6,7,7,8,8,8};

    logic signed [63:0] moment_sums[30];
    coef_t coef_queue[$];
    int mismatches = 0;
    int points_sent = 0;
    int runs_seen = 0;
    int coefs_checked = 0;
    logic accepted = 1'b0;

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // Adds one correspondence into the sums; on a final point queues the run.
    task automatic accumulate_point(input logic signed [15:0] px, py, qx, qy,
                                    input logic fin, input logic typed);
        longint w[9];
        longint one, u1, u2;
        wide_t part[30];
        wide_t t, hi_lim, lo_lim;
        coef_t c;
        one = longint'(1) << FRAC;
        u1 = longint'(px) * qy;
        u2 = longint'(qx) * py;
        w[0] = -(longint'(qy) + py) * one;
        w[1] = -2 * u1;
        w[2] = (longint'(qy) - py) * one;
        w[3] = (longint'(qx) - px) * one;
        w[4] = 2 * one * one + 2 * longint'(px) * qx;
        w[5] = -w[3];
        w[6] = u1 + u2;
        w[7] = -2 * longint'(qy) * one;
        w[8] = u2 - u1;
        hi_lim = 64'sh7fff_ffff_ffff_ffff;
        lo_lim = 64'sh8000_0000_0000_0000;
        foreach (part[i]) part[i] = '0;
        for (int i = 0; i < 45; i++) begin
            t = wide_t'(w[term_wa[i]]) * wide_t'(w[term_wb[i]]);
            part[term_slot[i]] += t * term_mul[i];
        end
        for (int i = 0; i < 30; i++) begin
            t = (part[i] + (wide_t'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
            if (t > hi_lim) t = hi_lim;
            if (t < lo_lim) t = lo_lim;
            moment_sums[i] = sat_sum(moment_sums[i], t[63:0]);
        end
        if (fin) begin
            for (int i = 0; i < 30; i++) begin
                c.idx = i[4:0];
                // An all-zero point leaves only the constant 2*2 term in slot 17.
                c.val = typed ? ((i == 17) ? 64'sh4000_0000 : 64'sh0) : moment_sums[i];
                c.last = (i == 29);
                coef_queue.push_back(c);
                moment_sums[i] = '0;
            end
        end
    endtask

    initial foreach (moment_sums[i]) moment_sums[i] = '0;

    always @(posedge aclk) begin
        accepted <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            accumulate_point(s_first_x, s_first_y, s_second_x, s_second_y, s_final_point, 1'b0);
        if (aresetn && m_valid && m_ready) begin
            coef_t e;
            coefs_checked++;
            if (m_run_end) runs_seen++;
            if (coef_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected coefficient idx=%0d val=%0d", m_coef_index, m_coef_value);
            end else begin
                e = coef_queue.pop_front();
                if (m_coef_index !== e.idx || m_coef_value !== e.val || m_run_end !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected idx=%0d val=%0d end=%0b, got idx=%0d val=%0d end=%0b",
                                 e.idx, e.val, e.last, m_coef_index, m_coef_value, m_run_end);
                end
            end
        end
    end

    // Receiver: bursts of ready with mostly short, sometimes long stalls;
    // some bursts are long enough to run without any stall.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            repeat (n - 1) @(negedge aclk);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            if (n > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // Presents one point at a falling edge, holds it until accepted and
    // drops valid at the falling edge after the accepting one.
    task automatic send_point(input point_row_t r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
        repeat (gap + 1) @(negedge aclk);
        s_valid <= 1'b1;
        s_first_x <= r.px;
        s_first_y <= r.py;
        s_second_x <= r.qx;
        s_second_y <= r.qy;
        s_final_point <= r.fin;
        do @(negedge aclk); while (!accepted);
        s_valid <= 1'b0;
        points_sent++;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    point_row_t directed[] = '{
        '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1},
        '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0},
        '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, 1'b0},
        '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, 1'b0},
        '{16'sh4000, 16'shc000, 16'sh2000, 16'sh1000, 1'b0, 1'b0},
        '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0},
        '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1},
        '{16'sh0001, 16'shffff, 16'sh5555, 16'shaaaa, 1'b0, 1'b0},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0},
        '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 1'b0}
    };

    initial begin
        point_row_t r;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) begin
            // Typed rows push their literal expectation through the predictor.
            if (directed[i].typed) begin
                wait (coef_queue.size() == 0);
                @(negedge aclk);
                send_point_typed(directed[i]);
            end else
                send_point(directed[i]);
        end
        for (int i = 0; i < NUM_RANDOM; i++) begin
            r.px = rand_coord();
            r.py = rand_coord();
            r.qx = rand_coord();
            r.qy = rand_coord();
            r.fin = (i == NUM_RANDOM - 1) || ($urandom_range(0, 4) == 0);
            r.typed = 1'b0;
            send_point(r);
        end
        wait (coef_queue.size() == 0);
        repeat (200) @(posedge aclk);
        $display("Sent %0d correspondences, checked %0d coefficients over %0d runs.",
                 points_sent, coefs_checked, runs_seen);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0 && coef_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // A typed row: the monitor predicts as usual, then the queued run is
    // replaced by the literal values read straight off the constant term.
    task automatic send_point_typed(input point_row_t r);
        send_point(r);
        @(posedge aclk);
        for (int i = 0; i < 30; i++)
            if (coef_queue.size() > 0) void'(coef_queue.pop_back());
        accumulate_point(r.px, r.py, r.qx, r.qy, 1'b1, 1'b1);
    endtask

    initial begin
        #50ms;
        $display("Timeout after %0d correspondences.", points_sent);
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> gravity_pose_moment_accumulator_core.f
+incdir+rtl
rtl/gpma_pkg.sv
rtl/gpma_datapath.sv
rtl/gpma_ctrl.sv
rtl/gravity_pose_moment_accumulator_core.sv
tb/sv/tb.sv
